// File: hdl/mm_pkg.sv
// Shared types and constants of the matrix multiply core.
package mm_pkg;

	localparam int IDX_W             = 3;
	localparam int SIZE_W            = 4;
	localparam int VAL_W             = 32;
	localparam int ACC_W             = 64;
	localparam int CFG_IDX_W         = 2;
	localparam int MAX_DIM_DEFAULT   = 8;
	localparam int FRAC_BITS_DEFAULT = 16;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd4;

	typedef enum logic [1:0] {
		OP_WRITE_A = 2'd0,
		OP_WRITE_B = 2'd1,
		OP_COMPUTE = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_A     = 2'd0,
		REG_INNER_SIZE = 2'd1,
		REG_COLS_B     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]              operation;
		logic [IDX_W-1:0]        row_index;
		logic [IDX_W-1:0]        col_index;
		logic signed [VAL_W-1:0] element_value;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]        out_row;
		logic [IDX_W-1:0]        out_col;
		logic signed [VAL_W-1:0] out_value;
		logic                    last;
	} res_t;

endpackage

// File: hdl/mm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: hdl/matrix_multiply_core.sv
// Matrix multiply core: C = A x B in signed fixed point, one shared MAC unit.
//
// Usage:
//   Command channel: drive command and raise start; the transaction is taken at
//   a rising edge where start is high and busy is low.
//   - OP_WRITE_A / OP_WRITE_B store one element of A or B. An element outside
//     the current sizes is dropped. Loads leave busy low, so a load can follow
//     every clock while no compute is in flight.
//   - OP_COMPUTE walks the stores and emits every product element in row-major
//     order on result, one per result_strobe pulse, with last set on the final
//     one. Operation code 3 is ignored.
//   Result channel: each result is present for exactly one cycle, marked by
//   result_strobe; the receiver cannot stall it.
//   Config port: cfg_write/cfg_index/cfg_data set rows_a, inner_size, cols_b
//   (sizes above MAX_DIM act as MAX_DIM); write only while busy is low.
// Timing: one multiply-accumulate per cycle through the single multiplier,
//   fed by the one read port of each store. A compute transaction keeps busy
//   high while its multiply-accumulate steps issue and until the pipeline
//   has drained. A compute with zero rows or columns emits nothing.
// Reset: sizes return to 4, the sequencer and pipeline clear; the stores keep
//   their contents and are undefined until written.
module matrix_multiply_core #(
	parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEFAULT,
	parameter int FRAC_BITS = mm_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  mm_pkg::cmd_t                   command,
	output logic                           result_strobe,
	output mm_pkg::res_t                   result,
	input  logic                           cfg_write,
	input  logic [mm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mm_pkg::SIZE_W-1:0]      cfg_data
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int IW     = mm_pkg::IDX_W;
	localparam int SW     = mm_pkg::SIZE_W;
	localparam int VW     = mm_pkg::VAL_W;
	localparam int AW     = mm_pkg::ACC_W;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// Tags that travel with each multiply-accumulate step.
	typedef struct packed {
		logic          first_k;
		logic          last_k;
		logic          last;
		logic          zero;
		logic [IW-1:0] row;
		logic [IW-1:0] col;
	} tag_t;

	state_t        state_q;
	logic [SW-1:0] rows_a_q, inner_size_q, cols_b_q;
	logic [IW-1:0] i_q, j_q, k_q;

	logic [SW-1:0] nr, nk, nc;
	logic          accept;
	logic          a_we, b_we;
	logic          a_in_range, b_in_range;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] a_rd_addr, b_rd_addr;
	logic [VW-1:0] a_rd_data, b_rd_data;
	logic          k_last, j_last, i_last;
	tag_t          issue_tag;

	logic          valid_s1, valid_s2, done_s3;
	tag_t          tag_s1, tag_s2;
	logic signed [AW-1:0] prod_s2;
	logic signed [AW-1:0] acc_q;
	tag_t          tag_s3;

	logic          result_strobe_q;
	mm_pkg::res_t  result_q;

	logic signed [AW-1:0] shifted;
	logic          overflow;
	logic signed [VW-1:0] sat_value;

	// Clamp size registers to the store dimension.
	assign nr = (rows_a_q > SW'(MAX_DIM)) ? SW'(MAX_DIM) : rows_a_q;
	assign nk = (inner_size_q > SW'(MAX_DIM)) ? SW'(MAX_DIM) : inner_size_q;
	assign nc = (cols_b_q > SW'(MAX_DIM)) ? SW'(MAX_DIM) : cols_b_q;

	assign busy   = (state_q == ST_RUN) || valid_s1 || valid_s2 || done_s3;
	assign accept = start && !busy;

	// Load path: range check against the current sizes, then write one store.
	assign a_in_range = ({1'b0, command.row_index} < nr) && ({1'b0, command.col_index} < nk);
	assign b_in_range = ({1'b0, command.row_index} < nk) && ({1'b0, command.col_index} < nc);
	assign a_we = accept && (command.operation == mm_pkg::OP_WRITE_A) && a_in_range;
	assign b_we = accept && (command.operation == mm_pkg::OP_WRITE_B) && b_in_range;
	assign wr_addr = ADDR_W'(int'(command.row_index) * MAX_DIM + int'(command.col_index));

	// Issue addresses: A(i,k) and B(k,j).
	assign a_rd_addr = ADDR_W'(int'(i_q) * MAX_DIM + int'(k_q));
	assign b_rd_addr = ADDR_W'(int'(k_q) * MAX_DIM + int'(j_q));

	// An inner size of zero runs one step with the product forced to zero.
	assign k_last = (nk == '0) || (({1'b0, k_q} + SW'(1)) == nk);
	assign j_last = ({1'b0, j_q} + SW'(1)) == nc;
	assign i_last = ({1'b0, i_q} + SW'(1)) == nr;

	always_comb begin
		issue_tag.first_k = (k_q == '0);
		issue_tag.last_k  = k_last;
		issue_tag.last    = k_last && j_last && i_last;
		issue_tag.zero    = (nk == '0);
		issue_tag.row     = i_q;
		issue_tag.col     = j_q;
	end

	mm_ram #(
		.WIDTH (VW),
		.DEPTH (DEPTH)
	) u_a_store (
		.clk     (clk),
		.wr_en   (a_we),
		.wr_addr (wr_addr),
		.wr_data (command.element_value),
		.rd_addr (a_rd_addr),
		.rd_data (a_rd_data)
	);

	mm_ram #(
		.WIDTH (VW),
		.DEPTH (DEPTH)
	) u_b_store (
		.clk     (clk),
		.wr_en   (b_we),
		.wr_addr (wr_addr),
		.wr_data (command.element_value),
		.rd_addr (b_rd_addr),
		.rd_data (b_rd_data)
	);

	// Sequencer, size registers, pipeline valids and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			rows_a_q        <= mm_pkg::SIZE_RESET;
			inner_size_q    <= mm_pkg::SIZE_RESET;
			cols_b_q        <= mm_pkg::SIZE_RESET;
			i_q             <= '0;
			j_q             <= '0;
			k_q             <= '0;
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
			done_s3         <= 1'b0;
			result_strobe_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					mm_pkg::REG_ROWS_A:     rows_a_q     <= cfg_data;
					mm_pkg::REG_INNER_SIZE: inner_size_q <= cfg_data;
					mm_pkg::REG_COLS_B:     cols_b_q     <= cfg_data;
					default: ;
				endcase
			end

			valid_s1        <= (state_q == ST_RUN);
			valid_s2        <= valid_s1;
			done_s3         <= valid_s2 && tag_s2.last_k;
			result_strobe_q <= done_s3;

			case (state_q)
				ST_IDLE: begin
					i_q <= '0;
					j_q <= '0;
					k_q <= '0;
					if (accept && (command.operation == mm_pkg::OP_COMPUTE) &&
					    (nr != '0) && (nc != '0)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					// Advance k, then column, then row; drop back when done.
					if (k_last) begin
						k_q <= '0;
						if (j_last) begin
							j_q <= '0;
							if (i_last) begin
								i_q     <= '0;
								state_q <= ST_IDLE;
							end else begin
								i_q <= i_q + IW'(1);
							end
						end else begin
							j_q <= j_q + IW'(1);
						end
					end else begin
						k_q <= k_q + IW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Scale back and clamp the finished sum.
	assign shifted  = acc_q >>> FRAC_BITS;
	assign overflow = (shifted[AW-1:VW-1] != '0) && (shifted[AW-1:VW-1] != '1);
	always_comb begin
		if (overflow) begin
			sat_value = shifted[AW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
		end else begin
			sat_value = shifted[VW-1:0];
		end
	end

	// Datapath: tag, multiply, accumulate, output.
	always_ff @(posedge clk) begin
		tag_s1 <= issue_tag;
		tag_s2 <= tag_s1;
		if (tag_s1.zero) begin
			prod_s2 <= '0;
		end else begin
			prod_s2 <= AW'($signed(a_rd_data)) * AW'($signed(b_rd_data));
		end
		if (valid_s2) begin
			acc_q  <= tag_s2.first_k ? prod_s2 : acc_q + prod_s2;
			tag_s3 <= tag_s2;
		end
		result_q.out_row   <= tag_s3.row;
		result_q.out_col   <= tag_s3.col;
		result_q.out_value <= sat_value;
		result_q.last      <= tag_s3.last;
	end

	assign result_strobe = result_strobe_q;
	assign result        = result_q;

`ifndef SYNTHESIS
	a_no_write_while_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !(a_we || b_we))
		else $error("store written during compute");

	a_s1_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(state_q == ST_RUN))
		else $error("pipeline step without issue");

	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result without compute in flight");

	a_last_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.last) |-> !busy)
		else $error("work left after final result");
`endif

endmodule

// File: bench/matrix_multiply_core_tb.sv
// Self-checking testbench for matrix_multiply_core: directed and random load/compute traffic.
`timescale 1ns / 100ps

module matrix_multiply_core_tb;

	localparam int         MAX_DIM       = mm_pkg::MAX_DIM_DEFAULT;
	localparam int         FRAC_BITS     = mm_pkg::FRAC_BITS_DEFAULT;
	// operation code 3 has no name in the package; the core must ignore it
	localparam logic [1:0] OP_UNUSED     = 2'd3;
	// pause before a register write, well past the pipeline drain
	localparam int         SETTLE_CYCLES = 16;
	// cycles with no transaction of any kind before the run is declared hung
	localparam int         QUIET_LIMIT   = 5000;
	localparam longint     VALUE_MAX     = 64'sh0000_0000_7FFF_FFFF;
	localparam longint     VALUE_MIN     = -VALUE_MAX - 1;
	localparam logic signed [mm_pkg::VAL_W-1:0] ELEM_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [mm_pkg::VAL_W-1:0] ELEM_MIN = 32'sh8000_0000;
	// register select masks for configure()
	localparam bit [2:0]   SEL_ALL       = 3'b111;
	localparam bit [2:0]   SEL_COLS      = 3'(1 << mm_pkg::REG_COLS_B);

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	mm_pkg::cmd_t                 command;
	logic                         result_strobe;
	mm_pkg::res_t                 result;
	logic                         cfg_write;
	logic [mm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mm_pkg::SIZE_W-1:0]    cfg_data;

	// Predictor state: sizes, operand stores and which entries hold data.
	logic [mm_pkg::SIZE_W-1:0]       size_rows  = mm_pkg::SIZE_RESET;
	logic [mm_pkg::SIZE_W-1:0]       size_inner = mm_pkg::SIZE_RESET;
	logic [mm_pkg::SIZE_W-1:0]       size_cols  = mm_pkg::SIZE_RESET;
	logic signed [mm_pkg::VAL_W-1:0] a_matrix [MAX_DIM][MAX_DIM];
	logic signed [mm_pkg::VAL_W-1:0] b_matrix [MAX_DIM][MAX_DIM];
	bit                              a_loaded [MAX_DIM][MAX_DIM];
	bit                              b_loaded [MAX_DIM][MAX_DIM];

	// Product elements still owed by the core, oldest first.
	mm_pkg::res_t expected_products [$];
	mm_pkg::res_t product_due;
	int unsigned  mismatch_count = 0;
	int unsigned  quiet_cycles   = 0;
	int unsigned  idle_pct       = 0;
	bit           start_held     = 1'b0;

	matrix_multiply_core #(
		.MAX_DIM   (MAX_DIM),
		.FRAC_BITS (FRAC_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.result_strobe (result_strobe),
		.result        (result),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sizes above MAX_DIM saturate; zero stays zero.
	function automatic int unsigned clip_size(logic [mm_pkg::SIZE_W-1:0] v);
		return (v > MAX_DIM) ? MAX_DIM : int'(v);
	endfunction

	// Advance the predictor by one accepted command transaction. Loads update
	// the stores when in range; a compute queues every product element in
	// row-major order.
	function automatic void update_product_model(mm_pkg::cmd_t cmd);
		int unsigned  nr;
		int unsigned  nk;
		int unsigned  nc;
		longint       acc;
		longint       scaled;
		mm_pkg::res_t elem;
		nr = clip_size(size_rows);
		nk = clip_size(size_inner);
		nc = clip_size(size_cols);
		case (cmd.operation)
			mm_pkg::OP_WRITE_A: begin
				if (cmd.row_index < nr && cmd.col_index < nk) begin
					a_matrix[cmd.row_index][cmd.col_index] = cmd.element_value;
					a_loaded[cmd.row_index][cmd.col_index] = 1'b1;
				end
			end
			mm_pkg::OP_WRITE_B: begin
				if (cmd.row_index < nk && cmd.col_index < nc) begin
					b_matrix[cmd.row_index][cmd.col_index] = cmd.element_value;
					b_loaded[cmd.row_index][cmd.col_index] = 1'b1;
				end
			end
			mm_pkg::OP_COMPUTE: begin
				for (int i = 0; i < nr; i++) begin
					for (int j = 0; j < nc; j++) begin
						// full 64-bit products, sum wraps modulo 2^64
						acc = 0;
						for (int k = 0; k < nk; k++)
							acc += longint'(a_matrix[i][k]) * longint'(b_matrix[k][j]);
						// arithmetic shift rounds toward minus infinity, then clamp
						scaled = acc >>> FRAC_BITS;
						if (scaled > VALUE_MAX)
							scaled = VALUE_MAX;
						else if (scaled < VALUE_MIN)
							scaled = VALUE_MIN;
						elem.out_row   = mm_pkg::IDX_W'(i);
						elem.out_col   = mm_pkg::IDX_W'(j);
						elem.out_value = scaled[mm_pkg::VAL_W-1:0];
						elem.last      = (i == nr - 1) && (j == nc - 1);
						expected_products.push_back(elem);
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic mm_pkg::cmd_t make_command(logic [1:0] op, int unsigned r,
			int unsigned c, logic signed [mm_pkg::VAL_W-1:0] v);
		mm_pkg::cmd_t cmd;
		cmd.operation     = op;
		cmd.row_index     = mm_pkg::IDX_W'(r);
		cmd.col_index     = mm_pkg::IDX_W'(c);
		cmd.element_value = v;
		return cmd;
	endfunction

	// Mix extremes, full-range words and values of a few units so that not
	// every product saturates.
	function automatic logic signed [mm_pkg::VAL_W-1:0] rand_element();
		logic [mm_pkg::VAL_W-1:0] bits;
		bits = $urandom;
		case ($urandom_range(7))
			0: return ELEM_MAX;
			1: return ELEM_MIN;
			2, 3: return bits;
			default: return {{14{bits[17]}}, bits[17:0]};
		endcase
	endfunction

	// Mostly small sizes; now and then zero or a value at or above MAX_DIM.
	function automatic logic [mm_pkg::SIZE_W-1:0] pick_size();
		case ($urandom_range(15))
			0: return '0;
			1, 2: return mm_pkg::SIZE_W'($urandom_range(15, MAX_DIM));
			default: return mm_pkg::SIZE_W'($urandom_range(3, 1));
		endcase
	endfunction

	// Present one command, hold it until the core takes it, then either keep
	// start high for a back-to-back transaction or drop it for a random gap.
	task automatic send_command(input mm_pkg::cmd_t cmd);
		command   <= cmd;
		start     <= 1'b1;
		start_held = 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		update_product_model(cmd);
		if ($urandom_range(99) < idle_pct) begin
			start     <= 1'b0;
			start_held = 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	// Drop start, wait for every owed product element, let the pipeline drain.
	task automatic settle_core();
		if (start_held) begin
			start     <= 1'b0;
			start_held = 1'b0;
		end
		while (expected_products.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic write_size(input mm_pkg::cfg_reg_t idx,
			input logic [mm_pkg::SIZE_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			mm_pkg::REG_ROWS_A:     size_rows  = val;
			mm_pkg::REG_INNER_SIZE: size_inner = val;
			mm_pkg::REG_COLS_B:     size_cols  = val;
			default: ;
		endcase
	endtask

	// Write the selected size registers once the core is idle.
	task automatic configure(input bit [2:0] sel, input logic [mm_pkg::SIZE_W-1:0] rows,
			input logic [mm_pkg::SIZE_W-1:0] inner, input logic [mm_pkg::SIZE_W-1:0] cols);
		settle_core();
		if (sel[mm_pkg::REG_ROWS_A])
			write_size(mm_pkg::REG_ROWS_A, rows);
		if (sel[mm_pkg::REG_INNER_SIZE])
			write_size(mm_pkg::REG_INNER_SIZE, inner);
		if (sel[mm_pkg::REG_COLS_B])
			write_size(mm_pkg::REG_COLS_B, cols);
		cfg_write <= 1'b0;
	endtask

	task automatic send_compute();
		send_command(make_command(mm_pkg::OP_COMPUTE, $urandom_range(7), $urandom_range(7),
			$urandom));
	endtask

	// Matrix-vector case at the reset sizes of rows and inner dimension:
	// accumulator wrap, saturation both ways, rounding of small negatives,
	// dropped out-of-range loads and the unused operation.
	task automatic test_matrix_vector_extremes();
		logic signed [mm_pkg::VAL_W-1:0] a_rows [4][4];
		logic signed [mm_pkg::VAL_W-1:0] b_col [4];
		// row 0 wraps past 2^63 and lands negative, row 1 saturates high,
		// row 2 is -1 LSB before the shift, row 3 mixes the extremes
		a_rows = '{'{ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN},
			'{ELEM_MIN, 0, 0, 0},
			'{0, 0, 0, -1},
			'{ELEM_MAX, ELEM_MAX, 1, 32'sh0001_0000}};
		b_col = '{ELEM_MIN, ELEM_MIN, ELEM_MIN, 1};
		idle_pct = 0;
		// leave rows_a and inner_size at their reset value
		configure(SEL_COLS, '0, '0, 4'd1);
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				send_command(make_command(mm_pkg::OP_WRITE_A, r, c, a_rows[r][c]));
		for (int k = 0; k < 4; k++)
			send_command(make_command(mm_pkg::OP_WRITE_B, k, 0, b_col[k]));
		// out-of-range loads: each must leave the stores untouched
		send_command(make_command(mm_pkg::OP_WRITE_B, 0, 7, ELEM_MAX));
		send_command(make_command(mm_pkg::OP_WRITE_B, 7, 0, ELEM_MAX));
		send_command(make_command(mm_pkg::OP_WRITE_A, 4, 0, ELEM_MAX));
		send_command(make_command(mm_pkg::OP_WRITE_A, 7, 7, ELEM_MAX));
		send_command(make_command(OP_UNUSED, 0, 0, ELEM_MAX));
		send_compute();
	endtask

	// Largest product from the fewest loads: 8x1 times 1x8, with rows_a
	// written above MAX_DIM.
	task automatic test_outer_product();
		idle_pct = 0;
		configure(SEL_ALL, 4'd15, 4'd1, 4'd8);
		for (int i = 0; i < MAX_DIM; i++) begin
			send_command(make_command(mm_pkg::OP_WRITE_A, i, 0, rand_element()));
			send_command(make_command(mm_pkg::OP_WRITE_B, 0, i, rand_element()));
		end
		send_compute();
	endtask

	// Zero sizes: no rows or no columns emit nothing; no inner dimension
	// gives all-zero elements without touching the stores.
	task automatic test_zero_sizes();
		idle_pct = 0;
		configure(SEL_ALL, 4'd0, 4'd1, 4'd8);
		send_compute();
		send_command(make_command(OP_UNUSED, $urandom_range(7), $urandom_range(7), $urandom));
		configure(SEL_ALL, 4'd2, 4'd0, 4'd3);
		send_compute();
		configure(SEL_ALL, 4'd1, 4'd1, 4'd0);
		send_compute();
	endtask

	// Random well-formed sets: new sizes, reload of the operand regions
	// (entries never written are always loaded), a stray command now and
	// then, then one or two computes.
	task automatic test_random_products(input int unsigned idle, input int unsigned quota);
		int unsigned done;
		int unsigned nr;
		int unsigned nk;
		int unsigned nc;
		logic [1:0]  noise_op;
		idle_pct = idle;
		done     = 0;
		while (done < quota) begin
			configure(SEL_ALL, pick_size(), pick_size(), pick_size());
			nr = clip_size(size_rows);
			nk = clip_size(size_inner);
			nc = clip_size(size_cols);
			for (int k = 0; k < nr * nk + nk * nc; k++) begin
				if ($urandom_range(7) == 0) begin
					case ($urandom_range(2))
						0: noise_op = mm_pkg::OP_WRITE_A;
						1: noise_op = mm_pkg::OP_WRITE_B;
						default: noise_op = OP_UNUSED;
					endcase
					send_command(make_command(noise_op, $urandom_range(7), $urandom_range(7),
						rand_element()));
					done++;
				end
				if (k < nr * nk) begin
					if (!a_loaded[k / nk][k % nk] || $urandom_range(3) != 0) begin
						send_command(make_command(mm_pkg::OP_WRITE_A, k / nk, k % nk,
							rand_element()));
						done++;
					end
				end else if (!b_loaded[(k - nr * nk) / nc][(k - nr * nk) % nc] ||
						$urandom_range(3) != 0) begin
					send_command(make_command(mm_pkg::OP_WRITE_B, (k - nr * nk) / nc,
						(k - nr * nk) % nc, rand_element()));
					done++;
				end
			end
			repeat ($urandom_range(2, 1)) begin
				send_compute();
				done++;
			end
		end
	endtask

	// Compare each strobed product element with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_strobe === 1'b1) begin
			if (expected_products.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected element: row %0d col %0d value %h last %b", $time,
					result.out_row, result.out_col, result.out_value, result.last);
			end else begin
				product_due = expected_products.pop_front();
				if (result !== product_due) begin
					mismatch_count++;
					$display({"%0t: element mismatch: expected row %0d col %0d value %h ",
						"last %b, got row %0d col %0d value %h last %b"},
						$time, product_due.out_row, product_due.out_col,
						product_due.out_value, product_due.last, result.out_row,
						result.out_col, result.out_value, result.last);
				end
			end
		end
	end

	// Watchdog: any command, result or register transaction resets the count.
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || result_strobe === 1'b1 || cfg_write === 1'b1)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		command   = '0;
		cfg_write = 1'b0;
		cfg_index = mm_pkg::REG_ROWS_A;
		cfg_data  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_matrix_vector_extremes();
		test_outer_product();
		test_zero_sizes();
		test_random_products(0, 14);
		test_random_products(64, 14);
		test_random_products(12, 14);

		settle_core();
		if (mismatch_count == 0 && expected_products.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/mm_pkg.sv
hdl/mm_ram.sv
hdl/matrix_multiply_core.sv
bench/matrix_multiply_core_tb.sv
